// ===== rtl/sad_pkg.sv =====
// ----------------------------------------------------------------------------
// sad_pkg
// Shared types, register indexes and helpers of the stereo audio decimator.
// ----------------------------------------------------------------------------
package sad_pkg;

	localparam int ACC_WIDTH_DEF  = 32;
	localparam int MAX_FACTOR_DEF = 32;

	localparam int REG_IDX_W = 3;
	localparam int REG_DAT_W = 6;

	localparam logic [REG_IDX_W-1:0] REG_FACTOR = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HALF   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MONO   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_EIGHT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WAIT   = 3'd4;

	typedef struct packed {
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
		logic               flush;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_left;
		logic [15:0] out_right;
	} out_item_t;

	typedef struct packed {
		logic [5:0] decimation_factor;
		logic       half_step_mode;
		logic       mono_output;
		logic       eight_bit_output;
		logic       wait_for_signal;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_NONE    = 2'd0,
		PH_ONE     = 2'd1,
		PH_TWO     = 2'd2,
		PH_COLLECT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DIV  = 2'd1,
		BK_DONE = 2'd2
	} back_state_t;

	// Clamp the programmed factor: zero acts as one, large values as the maximum.
	function automatic logic [6:0] clamp_factor(input logic [5:0] v, input logic [6:0] maxf);
		logic [6:0] f;
		f = {1'b0, v};
		if (f == 7'd0)
			f = 7'd1;
		if (f > maxf)
			f = maxf;
		return f;
	endfunction

endpackage

// ===== rtl/sad_fifo.sv =====
// ----------------------------------------------------------------------------
// sad_fifo
// Two-entry queue of division jobs between front and back.
// ----------------------------------------------------------------------------
module sad_fifo #(
	parameter int WIDTH = 66
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// ===== rtl/sad_front.sv =====
// ----------------------------------------------------------------------------
// sad_front
// Accept samples, keep the group sums and queue numerators for division.
// ----------------------------------------------------------------------------
module sad_front #(
	parameter int ACC_WIDTH  = sad_pkg::ACC_WIDTH_DEF,
	parameter int MAX_FACTOR = sad_pkg::MAX_FACTOR_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sad_pkg::cfg_t           cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  sad_pkg::in_item_t       in_item,
	output logic                    push,
	output logic [2*ACC_WIDTH+1:0]  push_data,
	input  logic                    full
);

	localparam int CW = $clog2(MAX_FACTOR + 1);
	localparam int NW = ACC_WIDTH + 1;

	sad_pkg::phase_t        phase_q, phase_n;
	logic [CW-1:0]          cd_q, cd_n;
	logic [ACC_WIDTH-1:0]   sum_l_q, sum_r_q, sec_l_q, sec_r_q, thr_l_q, thr_r_q;
	logic [ACC_WIDTH-1:0]   sum_l_n, sum_r_n, sec_l_n, sec_r_n, thr_l_n, thr_r_n;
	logic [15:0]            car_l_q, car_r_q, car_l_n, car_r_n;
	logic                   tog_q, tog_n;

	logic [CW-1:0]          f;
	logic                   half, pass, acc_item, fin;
	logic [ACC_WIDTH-1:0]   xl, xr, tv_l, tv_r;
	logic [15:0]            cv_l, cv_r;
	logic signed [NW-1:0]   num_l, num_r;

	// (3a + 6b - c) / 8, truncated toward zero
	function automatic logic signed [NW-1:0] quad(input logic [ACC_WIDTH-1:0] a,
			input logic [ACC_WIDTH-1:0] b, input logic [ACC_WIDTH-1:0] c);
		logic signed [ACC_WIDTH+3:0] ta, tb, tc, t;
		ta = {{4{a[ACC_WIDTH-1]}}, a};
		tb = {{4{b[ACC_WIDTH-1]}}, b};
		tc = {{4{c[ACC_WIDTH-1]}}, c};
		t  = (ta <<< 1) + ta + (tb <<< 2) + (tb <<< 1) - tc;
		if (t[ACC_WIDTH+3])
			t = t + (ACC_WIDTH+4)'(7);
		t = t >>> 3;
		return t[NW-1:0];
	endfunction

	assign f        = CW'(sad_pkg::clamp_factor(cfg.decimation_factor, 7'(MAX_FACTOR)));
	assign half     = cfg.half_step_mode && !tog_q;
	assign pass     = (f == CW'(1)) && !cfg.half_step_mode && !cfg.mono_output &&
		!cfg.eight_bit_output && (cd_q == CW'(1));
	assign in_ready = !full;
	assign acc_item = in_valid && in_ready;
	assign xl       = {{(ACC_WIDTH-16){in_item.left_in[15]}}, in_item.left_in};
	assign xr       = {{(ACC_WIDTH-16){in_item.right_in[15]}}, in_item.right_in};
	assign push_data = {num_l, num_r};

	always_comb begin
		phase_n = phase_q;
		cd_n    = cd_q;
		sum_l_n = sum_l_q;
		sum_r_n = sum_r_q;
		sec_l_n = sec_l_q;
		sec_r_n = sec_r_q;
		thr_l_n = thr_l_q;
		thr_r_n = thr_r_q;
		car_l_n = car_l_q;
		car_r_n = car_r_q;
		tog_n   = tog_q;
		push    = 1'b0;
		fin     = 1'b0;
		tv_l    = thr_l_q;
		tv_r    = thr_r_q;
		cv_l    = car_l_q;
		cv_r    = car_r_q;
		num_l   = '0;
		num_r   = '0;
		if (acc_item) begin
			if (pass) begin
				if (!in_item.flush) begin
					push  = 1'b1;
					num_l = {xl[ACC_WIDTH-1], xl};
					num_r = {xr[ACC_WIDTH-1], xr};
				end
			end else if (in_item.flush) begin
				push = 1'b1;
				if (half) begin
					num_l = quad(sum_l_q, sec_l_q, thr_l_q);
					num_r = quad(sum_r_q, sec_r_q, thr_r_q);
				end else begin
					num_l = {sum_l_q[ACC_WIDTH-1], sum_l_q};
					num_r = {sum_r_q[ACC_WIDTH-1], sum_r_q};
				end
				sum_l_n = '0;
				sum_r_n = '0;
				sec_l_n = '0;
				sec_r_n = '0;
				thr_l_n = '0;
				thr_r_n = '0;
				car_l_n = '0;
				car_r_n = '0;
				cd_n    = f;
				tog_n   = ~tog_q;
				phase_n = sad_pkg::PH_COLLECT;
			end else begin
				if (phase_q == sad_pkg::PH_COLLECT && cd_q != '0) begin
					cd_n    = cd_q - CW'(1);
					sum_l_n = sum_l_q + xl;
					sum_r_n = sum_r_q + xr;
					if (half) begin
						if ({1'b0, cd_n} + (CW+1)'(1) < {1'b0, f}) begin
							sec_l_n = sec_l_q + xl;
							sec_r_n = sec_r_q + xr;
						end
						if ({1'b0, cd_n} + (CW+1)'(2) < {1'b0, f}) begin
							thr_l_n = thr_l_q + xl;
							thr_r_n = thr_r_q + xr;
						end
					end
				end else if (phase_q == sad_pkg::PH_COLLECT && !half) begin
					cv_l = in_item.left_in;
					cv_r = in_item.right_in;
					fin  = 1'b1;
				end else if (phase_q == sad_pkg::PH_COLLECT || phase_q == sad_pkg::PH_TWO) begin
					sec_l_n = sec_l_q + xl;
					sec_r_n = sec_r_q + xr;
					if (f > CW'(1)) begin
						thr_l_n = thr_l_q + xl;
						thr_r_n = thr_r_q + xr;
					end
					phase_n = sad_pkg::PH_ONE;
				end else begin
					if (phase_q == sad_pkg::PH_ONE) begin
						cv_l = in_item.left_in;
						cv_r = in_item.right_in;
						tv_l = thr_l_q + xl;
						tv_r = thr_r_q + xr;
					end
					fin = 1'b1;
				end
				if (fin) begin
					push = 1'b1;
					if (half) begin
						num_l = quad(sum_l_q, sec_l_q, tv_l);
						num_r = quad(sum_r_q, sec_r_q, tv_r);
					end else begin
						num_l = {sum_l_q[ACC_WIDTH-1], sum_l_q};
						num_r = {sum_r_q[ACC_WIDTH-1], sum_r_q};
					end
					sum_l_n = {{(ACC_WIDTH-16){cv_l[15]}}, cv_l};
					sum_r_n = {{(ACC_WIDTH-16){cv_r[15]}}, cv_r};
					sec_l_n = '0;
					sec_r_n = '0;
					thr_l_n = '0;
					thr_r_n = '0;
					car_l_n = '0;
					car_r_n = '0;
					cd_n    = f - CW'(1);
					tog_n   = ~tog_q;
					phase_n = sad_pkg::PH_COLLECT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sad_pkg::PH_COLLECT;
			cd_q    <= CW'(1);
			sum_l_q <= '0;
			sum_r_q <= '0;
			sec_l_q <= '0;
			sec_r_q <= '0;
			thr_l_q <= '0;
			thr_r_q <= '0;
			car_l_q <= '0;
			car_r_q <= '0;
			tog_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			cd_q    <= cd_n;
			sum_l_q <= sum_l_n;
			sum_r_q <= sum_r_n;
			sec_l_q <= sec_l_n;
			sec_r_q <= sec_r_n;
			thr_l_q <= thr_l_n;
			thr_r_q <= thr_r_n;
			car_l_q <= car_l_n;
			car_r_q <= car_r_n;
			tog_q   <= tog_n;
		end
	end

endmodule

// ===== rtl/sad_back.sv =====
// ----------------------------------------------------------------------------
// sad_back
// Divide queued numerators by the factor, format and hold the result item.
// ----------------------------------------------------------------------------
module sad_back #(
	parameter int ACC_WIDTH  = sad_pkg::ACC_WIDTH_DEF,
	parameter int MAX_FACTOR = sad_pkg::MAX_FACTOR_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sad_pkg::cfg_t          cfg,
	input  logic                   job_valid,
	input  logic [2*ACC_WIDTH+1:0] job_data,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sad_pkg::out_item_t     out_item
);

	localparam int CW    = $clog2(MAX_FACTOR + 1);
	localparam int NW    = ACC_WIDTH + 1;
	localparam int DW    = ((NW + 2) / 3) * 3;
	localparam int STEPS = DW / 3;
	localparam int SW    = $clog2(STEPS + 1);

	sad_pkg::back_state_t state_q, state_n;
	logic [DW-1:0]        dvd_l_q, dvd_r_q, dvd_l_n, dvd_r_n;
	logic [CW-1:0]        rem_l_q, rem_r_q, rem_l_n, rem_r_n;
	logic [CW-1:0]        div_q;
	logic                 neg_l_q, neg_r_q;
	logic [SW-1:0]        cnt_q;
	logic                 seen_q, seen_n;
	logic                 out_valid_q;
	sad_pkg::out_item_t   out_item_q, fmt;
	logic                 load_job, load_out, last_step;

	logic signed [NW-1:0]      nl, nr;
	logic [NW-1:0]             ml, mr;
	logic signed [NW:0]        ql, qr;
	logic signed [NW+1:0]      msum, msh;
	logic signed [NW:0]        shl, shr;
	logic [15:0]               a, b, s;
	logic                      nz, emit;

	// Three restoring division steps per cycle
	function automatic logic [DW+CW-1:0] div3(input logic [DW-1:0] dvd,
			input logic [CW-1:0] rem, input logic [CW-1:0] d);
		logic [DW-1:0] q;
		logic [CW-1:0] r;
		logic [CW:0]   t;
		q = dvd;
		r = rem;
		for (int i = 0; i < 3; i++) begin
			t = {r, q[DW-1]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				q = {q[DW-2:0], 1'b1};
			end else begin
				q = {q[DW-2:0], 1'b0};
			end
			r = t[CW-1:0];
		end
		return {q, r};
	endfunction

	assign nl = job_data[2*NW-1:NW];
	assign nr = job_data[NW-1:0];
	assign ml = nl[NW-1] ? NW'(-nl) : NW'(nl);
	assign mr = nr[NW-1] ? NW'(-nr) : NW'(nr);

	assign {dvd_l_n, rem_l_n} = div3(dvd_l_q, rem_l_q, div_q);
	assign {dvd_r_n, rem_r_n} = div3(dvd_r_q, rem_r_q, div_q);
	assign last_step = (cnt_q == SW'(STEPS - 1));

	// Signed quotients, truncated toward zero
	assign ql = neg_l_q ? -{1'b0, dvd_l_q[NW-1:0]} : {1'b0, dvd_l_q[NW-1:0]};
	assign qr = neg_r_q ? -{1'b0, dvd_r_q[NW-1:0]} : {1'b0, dvd_r_q[NW-1:0]};

	always_comb begin
		msum = {ql[NW], ql} + {qr[NW], qr};
		msh  = cfg.eight_bit_output ? (msum >>> 9) : (msum >>> 1);
		shl  = cfg.eight_bit_output ? (ql >>> 8) : ql;
		shr  = cfg.eight_bit_output ? (qr >>> 8) : qr;
		s    = msh[15:0];
		a    = shl[15:0];
		b    = shr[15:0];
		if (cfg.mono_output) begin
			fmt.out_right = '0;
			if (cfg.eight_bit_output) begin
				nz           = (s[7:0] != 8'd0);
				fmt.out_left = {8'd0, s[7:0] + 8'h80};
			end else begin
				nz           = (s != 16'd0);
				fmt.out_left = s;
			end
		end else if (cfg.eight_bit_output) begin
			nz            = (a[7:0] != 8'd0) || (b[7:0] != 8'd0);
			fmt.out_left  = {8'd0, a[7:0] + 8'h80};
			fmt.out_right = {8'd0, b[7:0] + 8'h80};
		end else begin
			nz            = (a != 16'd0) || (b != 16'd0);
			fmt.out_left  = a;
			fmt.out_right = b;
		end
		seen_n = seen_q || nz;
		emit   = !cfg.wait_for_signal || seen_n;
	end

	always_comb begin
		state_n  = state_q;
		load_job = 1'b0;
		load_out = 1'b0;
		case (state_q)
			sad_pkg::BK_IDLE: begin
				if (job_valid) begin
					load_job = 1'b1;
					state_n  = sad_pkg::BK_DIV;
				end
			end
			sad_pkg::BK_DIV: begin
				if (last_step)
					state_n = sad_pkg::BK_DONE;
			end
			sad_pkg::BK_DONE: begin
				if (!emit) begin
					state_n = sad_pkg::BK_IDLE;
				end else if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_n  = sad_pkg::BK_IDLE;
				end
			end
			default: state_n = sad_pkg::BK_IDLE;
		endcase
	end

	assign pop       = load_job;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sad_pkg::BK_IDLE;
			cnt_q       <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_job)
				cnt_q <= '0;
			else if (state_q == sad_pkg::BK_DIV)
				cnt_q <= cnt_q + SW'(1);
			if (state_q == sad_pkg::BK_DONE && state_n == sad_pkg::BK_IDLE)
				seen_q <= seen_n;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			dvd_l_q <= DW'(ml);
			dvd_r_q <= DW'(mr);
			rem_l_q <= '0;
			rem_r_q <= '0;
			neg_l_q <= nl[NW-1];
			neg_r_q <= nr[NW-1];
			div_q   <= CW'(sad_pkg::clamp_factor(cfg.decimation_factor, 7'(MAX_FACTOR)));
		end else if (state_q == sad_pkg::BK_DIV) begin
			dvd_l_q <= dvd_l_n;
			dvd_r_q <= dvd_r_n;
			rem_l_q <= rem_l_n;
			rem_r_q <= rem_r_n;
		end
		if (load_out)
			out_item_q <= fmt;
	end

endmodule

// ===== rtl/stereo_audio_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_audio_decimator_unit
// Boxcar decimator for 16-bit stereo with half-step quadratic interpolation.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item): one stereo sample pair per item,
// or a flush item that, outside pass-through, emits the pending group and clears the sums.
// Output channel (out_valid/out_ready/out_item): one decimated sample pair.
// Configuration: wr_en/wr_index/wr_data write a register; write only while the block is idle.
// The front takes one item per cycle while its two-entry job queue has room;
// a flush outside pass-through, an item closing a group or any sample pair in pass-through queues a job.
// The back takes one job at a time and divides both channels by the factor
// three quotient bits per cycle: it loads a job in BK_IDLE, divides in
// BK_DIV and formats the result into the output register in BK_DONE.
// Reset clears the sums, sets the phase to collect and the countdown to one,
// returns the configuration registers to their reset values and clears the
// output valid flag. A stalled receiver holds the result in the output
// register; the back then waits and the queue fills, after which in_ready drops.
// ----------------------------------------------------------------------------
module stereo_audio_decimator_unit #(
	parameter int ACC_WIDTH  = sad_pkg::ACC_WIDTH_DEF,
	parameter int MAX_FACTOR = sad_pkg::MAX_FACTOR_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [sad_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [sad_pkg::REG_DAT_W-1:0]    wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sad_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output sad_pkg::out_item_t               out_item
);

	localparam int JW = 2 * (ACC_WIDTH + 1);

	sad_pkg::cfg_t   cfg_q;
	logic            push, full, pop, not_empty;
	logic [JW-1:0]   push_data, pop_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decimation_factor <= 6'd1;
			cfg_q.half_step_mode    <= 1'b0;
			cfg_q.mono_output       <= 1'b0;
			cfg_q.eight_bit_output  <= 1'b0;
			cfg_q.wait_for_signal   <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				sad_pkg::REG_FACTOR: cfg_q.decimation_factor <= wr_data;
				sad_pkg::REG_HALF:   cfg_q.half_step_mode    <= wr_data[0];
				sad_pkg::REG_MONO:   cfg_q.mono_output       <= wr_data[0];
				sad_pkg::REG_EIGHT:  cfg_q.eight_bit_output  <= wr_data[0];
				sad_pkg::REG_WAIT:   cfg_q.wait_for_signal   <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Front: accumulate groups, queue numerators
	sad_front #(
		.ACC_WIDTH  (ACC_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	sad_fifo #(
		.WIDTH (JW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	// Back: divide, format, hold the result
	sad_back #(
		.ACC_WIDTH  (ACC_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (not_empty),
		.job_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo audio decimator: a cycle-free predictor
// computes each decimated pair, random and directed sample streams run under
// several register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAXF = 32;
	localparam int SETTLE = 100; // cycles for jobs still in the queue and back end

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [sad_pkg::REG_IDX_W-1:0] wr_index = '0;
	logic [sad_pkg::REG_DAT_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	sad_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sad_pkg::out_item_t out_item;

	// Idle rates in percent and receiver hold-off.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold = 0;

	// Valid left high after the last accepted item.
	bit valid_held = 0;

	// Predictor copy of the configuration and state.
	int unsigned k_factor;
	bit k_half, k_mono, k_eight, k_wait;
	sad_pkg::phase_t k_phase;
	int k_count;
	longint s1l, s1r, s2l, s2r, s3l, s3r, cl, cr;
	bit k_toggle, k_seen;

	sad_pkg::out_item_t pairs_due[$];
	int n_sent = 0, n_got = 0, n_bad = 0, n_cfg = 0;

	stereo_audio_decimator_unit i_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item)
	);

	always #10 clk = ~clk;

	// Wrap to the accumulator width.
	function automatic longint wrap32(longint x);
		return longint'(int'(x));
	endfunction

	// Arithmetic right shift, rounds toward minus infinity.
	function automatic longint shr(longint x, int k);
		return x >>> k;
	endfunction

	function automatic int eff_factor();
		if (k_factor == 0) return 1;
		if (k_factor > MAXF) return MAXF;
		return k_factor;
	endfunction

	// Format one pair into the output item; return 1 if it is to be emitted.
	function automatic bit shape_pair(longint l, longint r, output sad_pkg::out_item_t o);
		int sh;
		logic [15:0] a, b;
		bit nz;
		sh = k_eight ? 8 : 0;
		o = '0;
		if (k_mono) begin
			a = 16'(shr(l + r, sh + 1));
			if (k_eight) begin
				nz = a[7:0] != 0;
				o.out_left = {8'd0, 8'(a + 16'd128)};
			end else begin
				nz = a != 0;
				o.out_left = a;
			end
		end else begin
			a = 16'(shr(l, sh));
			b = 16'(shr(r, sh));
			if (k_eight) begin
				nz = a[7:0] != 0 || b[7:0] != 0;
				o.out_left = {8'd0, 8'(a + 16'd128)};
				o.out_right = {8'd0, 8'(b + 16'd128)};
			end else begin
				nz = a != 0 || b != 0;
				o.out_left = a;
				o.out_right = b;
			end
		end
		if (nz) k_seen = 1;
		return !k_wait || k_seen;
	endfunction

	// Close the current group: plain average or quadratic interpolation.
	function automatic bit close_group(output sad_pkg::out_item_t o);
		longint l, r;
		int f;
		f = eff_factor();
		if (k_half && !k_toggle) begin
			l = ((3 * s1l + 6 * s2l - s3l) / 8) / f;
			r = ((3 * s1r + 6 * s2r - s3r) / 8) / f;
		end else begin
			l = s1l / f;
			r = s1r / f;
		end
		return shape_pair(l, r, o);
	endfunction

	task automatic reset_model();
		k_factor = 1; k_half = 0; k_mono = 0; k_eight = 0; k_wait = 0;
		k_phase = sad_pkg::PH_COLLECT; k_count = 1;
		s1l = 0; s1r = 0; s2l = 0; s2r = 0; s3l = 0; s3r = 0; cl = 0; cr = 0;
		k_toggle = 0; k_seen = 0;
	endtask

	// Advance the predictor by one accepted item and queue any result.
	task automatic decimate_item(sad_pkg::in_item_t it);
		longint l, r;
		int f;
		bit half, emit, ok;
		sad_pkg::out_item_t o;
		l = it.left_in;
		r = it.right_in;
		f = eff_factor();
		half = k_half && !k_toggle;
		emit = 0;
		if (f == 1 && !k_half && !k_mono && !k_eight && k_count == 1) begin
			if (it.flush) return;
			if (l != 0 || r != 0) k_seen = 1;
			o.out_left = it.left_in;
			o.out_right = it.right_in;
			if (!k_wait || k_seen) pairs_due.push_back(o);
			return;
		end
		if (it.flush) begin
			ok = close_group(o);
			k_count = f;
			s1l = 0; s1r = 0; s2l = 0; s2r = 0; s3l = 0; s3r = 0; cl = 0; cr = 0;
			k_toggle ^= 1;
			k_phase = sad_pkg::PH_COLLECT;
			if (ok) pairs_due.push_back(o);
			return;
		end
		if (k_phase == sad_pkg::PH_COLLECT) begin
			if (k_count > 0) begin
				k_count--;
				s1l = wrap32(s1l + l); s1r = wrap32(s1r + r);
				if (half) begin
					if (k_count < f - 1) begin
						s2l = wrap32(s2l + l); s2r = wrap32(s2r + r);
					end
					if (k_count < f - 2) begin
						s3l = wrap32(s3l + l); s3r = wrap32(s3r + r);
					end
				end
				return;
			end
			if (half) k_phase = sad_pkg::PH_TWO;
			else begin
				cl = l; cr = r; emit = 1;
			end
		end
		if (!emit) begin
			if (k_phase == sad_pkg::PH_TWO) begin
				s2l = wrap32(s2l + l); s2r = wrap32(s2r + r);
				if (f > 1) begin
					s3l = wrap32(s3l + l); s3r = wrap32(s3r + r);
				end
				k_phase = sad_pkg::PH_ONE;
				return;
			end
			if (k_phase == sad_pkg::PH_ONE) begin
				cl = l; cr = r;
				s3l = wrap32(s3l + l); s3r = wrap32(s3r + r);
			end
		end
		ok = close_group(o);
		k_count = f - 1;
		s1l = cl; s1r = cr;
		s2l = 0; s2r = 0; s3l = 0; s3r = 0; cl = 0; cr = 0;
		k_toggle ^= 1;
		k_phase = sad_pkg::PH_COLLECT;
		if (ok) pairs_due.push_back(o);
	endtask

	// Send one item; hold valid and payload until accepted.
	task automatic send_item(sad_pkg::in_item_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			if (valid_held) begin
				in_valid <= 1'b0;
				valid_held = 0;
			end
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		valid_held = 1;
		do @(posedge clk); while (!in_ready);
		decimate_item(it);
		n_sent++;
	endtask

	task automatic send_pair(int l, int r);
		sad_pkg::in_item_t it;
		it.left_in = 16'(l);
		it.right_in = 16'(r);
		it.flush = 1'b0;
		send_item(it);
	endtask

	task automatic send_flush();
		sad_pkg::in_item_t it;
		it.left_in = 16'($urandom);
		it.right_in = 16'($urandom);
		it.flush = 1'b1;
		send_item(it);
	endtask

	// Wait until all results are in, then let the back end drain.
	task automatic drain();
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 0;
		end
		@(posedge clk);
		while (pairs_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [sad_pkg::REG_IDX_W-1:0] idx, int v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= sad_pkg::REG_DAT_W'(v);
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			sad_pkg::REG_FACTOR: k_factor = v & 6'h3f;
			sad_pkg::REG_HALF: k_half = v & 1;
			sad_pkg::REG_MONO: k_mono = v & 1;
			sad_pkg::REG_EIGHT: k_eight = v & 1;
			sad_pkg::REG_WAIT: k_wait = v & 1;
			default: ;
		endcase
		n_cfg++;
		@(posedge clk);
	endtask

	task automatic set_config(int f, bit h, bit m, bit e, bit w);
		write_reg(sad_pkg::REG_FACTOR, f);
		write_reg(sad_pkg::REG_HALF, h);
		write_reg(sad_pkg::REG_MONO, m);
		write_reg(sad_pkg::REG_EIGHT, e);
		write_reg(sad_pkg::REG_WAIT, w);
	endtask

	// Random sample, biased toward the extremes and zero.
	function automatic int pick_sample();
		case ($urandom_range(7))
			0: return 32767;
			1: return -32768;
			2: return 0;
			default: return int'(16'($urandom)) - ((($urandom & 1) != 0) ? 0 : 0);
		endcase
	endfunction

	// Pass-through at reset values, plus field extremes and waiting for signal.
	task automatic test_passthrough();
		send_pair(32767, -32768);
		send_pair(-32768, 32767);
		send_pair(0, 0);
		send_flush();
		send_pair(-1, 1);
		drain();
		write_reg(sad_pkg::REG_WAIT, 1);
		send_pair(0, 0);
		send_pair(0, 0);
		send_pair(5, 0);
		send_pair(0, 0);
		drain();
		write_reg(sad_pkg::REG_WAIT, 0);
	endtask

	// Each mode at least once: averaging, half step, mono, eight bit, waiting for signal, zero and big factor.
	task automatic test_modes();
		set_config(3, 0, 0, 0, 0);
		repeat (7) send_pair(32767, -32768);
		send_flush();
		drain();
		set_config(2, 1, 1, 1, 0);
		repeat (6) send_pair(-32768, -32768);
		drain();
		set_config(0, 0, 0, 1, 0);
		send_pair(-129, 300);
		send_pair(1, -1);
		drain();
		set_config(63, 0, 1, 0, 1);
		send_flush();
		drain();
	endtask

	// Random streams under a spread of settings.
	task automatic test_random(int n);
		int f;
		set_config(1, 0, 0, 0, 0);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) begin
				drain();
				f = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(1, 6);
				set_config(f, $urandom_range(1), $urandom_range(1), $urandom_range(1),
					($urandom_range(4) == 0));
			end
			if ($urandom_range(40) == 0) send_flush();
			else send_pair(pick_sample(), pick_sample());
		end
		drain();
	endtask

	// Receiver holds off while items keep coming so the block backs up.
	task automatic test_backpressure();
		set_config(1, 0, 0, 0, 0);
		recv_hold = 300;
		repeat (20) send_pair(pick_sample(), pick_sample());
		drain();
	endtask

	// Receiver side: random ready, long hold-off when requested.
	always @(posedge clk) begin
		if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			out_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_got++;
			if (pairs_due.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result %h", out_item);
			end else begin
				sad_pkg::out_item_t e;
				e = pairs_due.pop_front();
				if (e.out_left !== out_item.out_left || e.out_right !== out_item.out_right) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch %0d: expected %h/%h got %h/%h", n_got,
							e.out_left, e.out_right, out_item.out_left, out_item.out_right);
				end
			end
		end
	end

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_modes();
		send_idle_pct = 12; recv_idle_pct = 56;
		test_random(280);
		send_idle_pct = 56; recv_idle_pct = 12;
		test_random(280);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(240);
		test_backpressure();
		$display("Sent %0d items, checked %0d results, %0d register writes.",
			n_sent, n_got, n_cfg);
		if (n_bad == 0 && pairs_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
